@@ rtl/cfcf_pkg.sv @@
`timescale 1ns / 1ps

package cfcf_pkg;

    localparam int ID_W   = 11;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;

    // longest legal data length; longer codes are clipped to it
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

    localparam int CFCF_TABLE_ENTRIES = 32;

    typedef struct packed {
        logic              crc_good;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  raw_length;
        logic [DATA_W-1:0] payload;
    } frame_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_id;
        logic [LEN_W-1:0]  out_length;
        logic [DATA_W-1:0] out_payload;
        logic              was_stored;
    } frame_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load_frame;  // capture accepted frame, clear scan results
        logic scan_en;     // read next table entry
        logic commit;      // update table, load result register
    } cfcf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;   // address being read is the last entry
        logic match;       // identifier present with same length and data
        logic out_free;    // result register can take a new beat
    } cfcf_status_t;

endpackage

@@ rtl/can_frame_change_filter_top.sv @@
`timescale 1ns / 1ps

// CAN frame change filter. Each input beat is one received standard CAN frame.
// Frames with a bad CRC are taken and dropped at once. A good frame (length
// clipped to 8) is looked up in a table of TABLE_ENTRIES entries; if its
// identifier is there with the same length and all eight data bytes equal,
// nothing comes out. Otherwise the entry is updated, or the lowest free entry
// is claimed, and the frame goes out as one result beat; was_stored is 0 when
// the table was full and the frame was not kept. A good frame is taken, then the
// table is scanned through its single read port, one entry per cycle, the last
// entry is compared, and the frame is decided and, if reported, committed.
// A result beat waits in an output register, so the next frame is taken while
// it is pending; commit of that next frame stalls until the register frees.
// The table valid bits are cleared by reset; no clearing pass is needed.

module can_frame_change_filter_top
    import cfcf_pkg::*;
#(
    parameter int TABLE_ENTRIES = CFCF_TABLE_ENTRIES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  frame_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output frame_out_t out_data
);

    cfcf_cmd_t    cmd;
    cfcf_status_t status;

    // sequencer: take frame, scan table, decide and commit
    cfcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .crc_good (in_data.crc_good),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // table memory, valid bits, compare and result register
    cfcf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // an unchanged frame must never be reported
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !status.match)
        else $error("commit of a frame that matched its table entry");

    // a pending result beat is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while result register still full");

    // a bad-CRC frame leaves the block ready for the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_data.crc_good) |=> in_ready)
        else $error("bad-CRC frame started a table scan");

    // no input is taken while the table is being scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_en |-> !in_ready)
        else $error("input ready during table scan");

endmodule

@@ rtl/cfcf_ctrl.sv @@
`timescale 1ns / 1ps

module cfcf_ctrl
    import cfcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         crc_good,
    output logic         in_ready,
    input  cfcf_status_t status,
    output cfcf_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.load_frame = 1'b0;
        cmd.scan_en    = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // bad-CRC beats are taken and dropped here
                if (in_valid && crc_good)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last entry is compared in this cycle
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.match)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cfcf_datapath.sv @@
`timescale 1ns / 1ps

module cfcf_datapath
    import cfcf_pkg::*;
#(
    parameter int TABLE_ENTRIES = CFCF_TABLE_ENTRIES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  frame_in_t    in_data,
    input  cfcf_cmd_t    cmd,
    output cfcf_status_t status,
    output logic         out_valid,
    input  logic         out_ready,
    output frame_out_t   out_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } entry_t;

    entry_t mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    entry_t     frame_reg;
    entry_t     rd_data_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic       cmp_pend_reg;

    logic       hit_reg;
    logic       match_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic       free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic       out_valid_reg;
    frame_out_t out_data_reg;

    logic [LEN_W-1:0] clip_len;
    logic       rd_valid;
    logic       rd_hit;
    logic       stored;
    logic [IDX_W-1:0] slot;

    assign clip_len = (in_data.raw_length > MAX_LEN) ? MAX_LEN : in_data.raw_length;
    assign rd_valid = valid_reg[rd_idx_reg];
    assign rd_hit   = cmp_pend_reg && rd_valid && (rd_data_reg.id == frame_reg.id);
    assign stored   = hit_reg || free_reg;
    assign slot     = hit_reg ? hit_idx_reg : free_idx_reg;

    // table storage: one read port for the scan, one write at commit
    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
        if (cmd.commit && stored)
        begin
            mem[slot] <= frame_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            frame_reg.id   <= in_data.frame_id;
            frame_reg.len  <= clip_len;
            frame_reg.data <= in_data.payload;
        end
        if (cmd.scan_en)
        begin
            rd_idx_reg <= addr_reg;
        end
        if (rd_hit)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmp_pend_reg && !rd_valid && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            out_data_reg.out_id      <= frame_reg.id;
            out_data_reg.out_length  <= frame_reg.len;
            out_data_reg.out_payload <= frame_reg.data;
            out_data_reg.was_stored  <= stored;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            addr_reg      <= '0;
            cmp_pend_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_pend_reg <= cmd.scan_en;
            if (cmd.load_frame)
            begin
                addr_reg  <= '0;
                hit_reg   <= 1'b0;
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.scan_en)
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                // identifiers are unique in the table, so at most one hit
                if (rd_hit)
                begin
                    hit_reg   <= 1'b1;
                    match_reg <= (rd_data_reg.len == frame_reg.len)
                              && (rd_data_reg.data == frame_reg.data);
                end
                if (cmp_pend_reg && !rd_valid)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.commit && stored)
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.scan_last = (addr_reg == LAST_IDX);
    assign status.match     = match_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Change-filter check: directed frames from a table, then a long random run.
// Every accepted frame is pushed through a local copy of the identifier table,
// and any report it should cause is queued; result beats are checked against
// the queue in order.

module testbench;
    import cfcf_pkg::*;

    localparam int ENTRIES      = CFCF_TABLE_ENTRIES;
    localparam int NUM_FRAMES   = 540;     // good-CRC frames in the random part
    localparam int TAIL_FRAMES  = 80;      // closing stretch without idling
    localparam int POOL_SIZE    = 48;      // more than ENTRIES so the table fills
    localparam int STALL_LIMIT  = 2000;    // cycles with no beat on either side

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    frame_in_t  in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    frame_out_t out_data;

    // One row of the directed part. Rows marked by_hand carry their result
    // as typed below; the rest are checked against the table copy.
    typedef struct {
        frame_in_t  frame;
        bit         by_hand;
        bit         reports;
        frame_out_t report;
    } frame_row_t;

    frame_row_t directed_rows[$];

    // Local copy of the identifier table.
    bit               seen_valid   [ENTRIES];
    logic [ID_W-1:0]  seen_id      [ENTRIES];
    logic [LEN_W-1:0] seen_length  [ENTRIES];
    logic [DATA_W-1:0] seen_payload[ENTRIES];

    frame_out_t pending_reports[$];
    frame_out_t oldest_report;

    int  error_count  = 0;
    int  stall_cycles = 0;
    bit  idle_enable  = 1'b1;   // random idling on both sides

    can_frame_change_filter_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Table copy: works out whether a frame is reported and what it carries.
    // ------------------------------------------------------------------
    function automatic bit predict_change(input frame_in_t f, output frame_out_t r);
        logic [LEN_W-1:0] len;
        int               hit;
        int               slot;
        int               k;
        hit  = -1;
        slot = -1;
        r    = '0;
        if (!f.crc_good)
            return 1'b0;               // bad CRC: dropped, table untouched
        len = (f.raw_length > MAX_LEN) ? MAX_LEN : f.raw_length;
        for (k = 0; k < ENTRIES; k++)
        begin
            if (hit < 0 && seen_valid[k] && seen_id[k] == f.frame_id)
                hit = k;
        end
        if (hit >= 0)
        begin
            // all eight bytes count, even past the length
            if (seen_length[hit] == len && seen_payload[hit] == f.payload)
                return 1'b0;
            slot = hit;
        end
        else
        begin
            for (k = 0; k < ENTRIES; k++)
            begin
                if (slot < 0 && !seen_valid[k])
                    slot = k;          // lowest free entry
            end
        end
        if (slot >= 0)
        begin
            seen_valid[slot]   = 1'b1;
            seen_id[slot]      = f.frame_id;
            seen_length[slot]  = len;
            seen_payload[slot] = f.payload;
        end
        r.out_id      = f.frame_id;
        r.out_length  = len;
        r.out_payload = f.payload;
        r.was_stored  = (slot >= 0);
        return 1'b1;
    endfunction

    // Directed row builder. For rows done by hand the reported id and
    // payload are those of the frame itself.
    function automatic void add_row(input bit crc, input logic [ID_W-1:0] id,
                                    input logic [LEN_W-1:0] len,
                                    input logic [DATA_W-1:0] data,
                                    input bit by_hand, input bit reports,
                                    input logic [LEN_W-1:0] out_len,
                                    input bit stored);
        frame_row_t row;
        row.frame.crc_good    = crc;
        row.frame.frame_id    = id;
        row.frame.raw_length  = len;
        row.frame.payload     = data;
        row.by_hand           = by_hand;
        row.reports           = reports;
        row.report.out_id      = id;
        row.report.out_length  = out_len;
        row.report.out_payload = data;
        row.report.was_stored  = stored;
        directed_rows.push_back(row);
    endfunction

    // Drive one input beat and hold it until taken. The expectation is
    // queued at the accepting edge; a random gap may follow.
    task automatic send_frame(input frame_in_t f, input bit by_hand,
                              input bit reports, input frame_out_t hand_report);
        frame_out_t predicted;
        bit         fires;
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fires = predict_change(f, predicted);
        if (by_hand)
        begin
            if (reports)
                pending_reports.push_back(hand_report);
        end
        else if (fires)
        begin
            pending_reports.push_back(predicted);
        end
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        error_count++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts while idling is on.
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Every result beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected beat, out_id", '0, DATA_W'(out_data.out_id));
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                if (out_data.out_id !== oldest_report.out_id)
                    report_mismatch("out_id", DATA_W'(oldest_report.out_id),
                                    DATA_W'(out_data.out_id));
                if (out_data.out_length !== oldest_report.out_length)
                    report_mismatch("out_length", DATA_W'(oldest_report.out_length),
                                    DATA_W'(out_data.out_length));
                if (out_data.out_payload !== oldest_report.out_payload)
                    report_mismatch("out_payload", oldest_report.out_payload,
                                    out_data.out_payload);
                if (out_data.was_stored !== oldest_report.was_stored)
                    report_mismatch("was_stored", DATA_W'(oldest_report.was_stored),
                                    DATA_W'(out_data.was_stored));
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_reports.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [ID_W-1:0]   pool_id   [POOL_SIZE];
        logic [LEN_W-1:0]  pool_len  [POOL_SIZE];
        logic [DATA_W-1:0] pool_data [POOL_SIZE];
        bit                pool_sent [POOL_SIZE];
        bit                id_taken  [2**ID_W];
        frame_in_t         f;
        frame_out_t        no_report;
        logic [ID_W-1:0]   cand;
        int                good_count;
        int                active;
        int                idx;
        int                pick;
        bit                from_pool;

        no_report  = '0;
        good_count = 0;

        // Directed rows. After reset the table is empty, so the first good
        // frame of each identifier is a new entry.
        // bad CRC on an empty table: nothing
        add_row(1'b0, 11'h000, 4'd3,  64'h0123_4567_89AB_CDEF, 1, 0, 4'd0, 0);
        // all-zero frame, id 0 is a real identifier, not an empty marker
        add_row(1'b1, 11'h000, 4'd0,  64'h0,                   1, 1, 4'd0, 1);
        add_row(1'b1, 11'h000, 4'd0,  64'h0,                   1, 0, 4'd0, 0);
        // length code 15 clips to 8
        add_row(1'b1, 11'h000, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 4'd8, 1);
        // 8 and 9 both equal the stored clipped length
        add_row(1'b1, 11'h000, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 4'd0, 0);
        add_row(1'b1, 11'h000, 4'd9,  64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 4'd0, 0);
        add_row(1'b1, 11'h7FF, 4'd8,  64'hA5A5_A5A5_A5A5_A5A5, 1, 1, 4'd8, 1);
        // bad CRC with new data must not touch the entry
        add_row(1'b0, 11'h7FF, 4'd2,  64'h0,                   1, 0, 4'd0, 0);
        add_row(1'b1, 11'h7FF, 4'd8,  64'hA5A5_A5A5_A5A5_A5A5, 1, 0, 4'd0, 0);
        add_row(1'b1, 11'h7FF, 4'd8,  64'h5A5A_5A5A_5A5A_5A5A, 0, 0, 4'd0, 0);
        add_row(1'b1, 11'h7FF, 4'd1,  64'h5A5A_5A5A_5A5A_5A5A, 0, 0, 4'd0, 0);
        // change only in a byte past the length still counts
        add_row(1'b1, 11'h7FF, 4'd1,  64'h005A_5A5A_5A5A_5A5A, 0, 0, 4'd0, 0);
        add_row(1'b1, 11'h555, 4'd4,  64'h5555_5555_5555_5555, 1, 1, 4'd4, 1);
        add_row(1'b1, 11'h2AA, 4'd12, 64'hAAAA_AAAA_AAAA_AAAA, 1, 1, 4'd8, 1);
        add_row(1'b1, 11'h555, 4'd4,  64'h5555_5555_5555_5554, 0, 0, 4'd0, 0);
        add_row(1'b1, 11'h000, 4'd0,  64'h0,                   0, 0, 4'd0, 0);
        add_row(1'b1, 11'h400, 4'd7,  64'h8000_0000_0000_0001, 0, 0, 4'd0, 0);
        add_row(1'b0, 11'h400, 4'd0,  64'h8000_0000_0000_0001, 1, 0, 4'd0, 0);

        // Identifier pool for the random part; the active part grows past
        // the table size so the full-table case comes up late in the run.
        foreach (id_taken[i])
            id_taken[i] = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            cand = ID_W'($urandom_range(0, 2**ID_W - 1));
            while (id_taken[cand])
                cand = ID_W'($urandom_range(0, 2**ID_W - 1));
            id_taken[cand] = 1'b1;
            pool_id[i]     = cand;
            pool_len[i]    = '0;
            pool_data[i]   = '0;
            pool_sent[i]   = 1'b0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_frame(directed_rows[i].frame, directed_rows[i].by_hand,
                       directed_rows[i].reports, directed_rows[i].report);

        while (good_count < NUM_FRAMES)
        begin
            // idling off in every fourth block of 50 and in the tail
            idle_enable = (good_count < NUM_FRAMES - TAIL_FRAMES) &&
                          ((good_count / 50) % 4 != 3);
            pick       = $urandom_range(0, 99);
            active     = 16 + (good_count * (POOL_SIZE - 16)) / NUM_FRAMES;
            idx        = $urandom_range(0, active - 1);
            from_pool  = 1'b0;
            f.crc_good = 1'b1;
            if (pick < 8)
            begin
                // noise: bad CRC, anything else random
                f.crc_good   = 1'b0;
                f.frame_id   = ID_W'($urandom_range(0, 2**ID_W - 1));
                f.raw_length = LEN_W'($urandom_range(0, 15));
                f.payload    = {$urandom(), $urandom()};
            end
            else if (pick < 12)
            begin
                // stray random identifier, not drawn from the pool
                f.frame_id   = ID_W'($urandom_range(0, 2**ID_W - 1));
                f.raw_length = LEN_W'($urandom_range(0, 15));
                f.payload    = {$urandom(), $urandom()};
            end
            else if (pick < 50 && pool_sent[idx])
            begin
                // repeat of the last frame; any code above 8 is the same length
                from_pool    = 1'b1;
                f.frame_id   = pool_id[idx];
                f.payload    = pool_data[idx];
                f.raw_length = pool_len[idx];
                if (pool_len[idx] >= MAX_LEN)
                    f.raw_length = LEN_W'($urandom_range(8, 15));
            end
            else
            begin
                from_pool    = 1'b1;
                f.frame_id   = pool_id[idx];
                f.raw_length = pool_len[idx];
                f.payload    = pool_data[idx];
                case (pool_sent[idx] ? $urandom_range(0, 2) : 2)
                    0: f.payload = pool_data[idx] ^
                                   (DATA_W'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7)));
                    1: f.raw_length = LEN_W'($urandom_range(0, 15));
                    default:
                    begin
                        f.raw_length = LEN_W'($urandom_range(0, 15));
                        f.payload    = {$urandom(), $urandom()};
                    end
                endcase
            end
            if (from_pool)
            begin
                pool_len[idx]  = f.raw_length;
                pool_data[idx] = f.payload;
                pool_sent[idx] = 1'b1;
            end
            if (f.crc_good)
                good_count++;
            send_frame(f, 1'b0, 1'b0, no_report);
        end

        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        // a last unchanged frame may still be scanning; give it time to
        // show a stray beat
        repeat (ENTRIES + 10) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cfcf_pkg.sv
rtl/cfcf_ctrl.sv
rtl/cfcf_datapath.sv
rtl/can_frame_change_filter_top.sv
verif/testbench.sv
